### rtl/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// Shared types and constants for the axis min/max calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package amc_pkg;

	localparam int unsigned SampleBitsDef = 16;
	localparam int unsigned FracBitsDef   = 14;

	localparam int unsigned MinSpanBits  = 16;
	localparam logic [MinSpanBits-1:0] MinSpanReset = 16'd10000;

	localparam int unsigned ApbAddrBits = 3;
	localparam int unsigned ApbDataBits = 32;

	typedef enum logic [1:0] {
		ACT_SCALE  = 2'd0,
		ACT_BEGIN  = 2'd1,
		ACT_WIDEN  = 2'd2,
		ACT_CENTER = 2'd3
	} action_t;

	typedef enum logic {
		REG_MIN_SPAN = 1'b0
	} reg_idx_t;

endpackage

`default_nettype wire

### rtl/amc_in_if.sv
// ----------------------------------------------------------------------------
// amc_in_if
// Input channel: action and raw sample with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface amc_in_if #(
	parameter int unsigned SAMPLE_BITS = amc_pkg::SampleBitsDef
);
	logic                          valid;
	logic                          ready;
	amc_pkg::action_t              action;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

### rtl/amc_out_if.sv
// ----------------------------------------------------------------------------
// amc_out_if
// Output channel: calibrated value and current calibration with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface amc_out_if #(
	parameter int unsigned SAMPLE_BITS = amc_pkg::SampleBitsDef,
	parameter int unsigned FRAC_BITS   = amc_pkg::FracBitsDef
);
	logic                          valid;
	logic                          ready;
	logic signed [FRAC_BITS+1:0]   calibrated;
	logic signed [SAMPLE_BITS-1:0] center_now;
	logic signed [SAMPLE_BITS-1:0] min_now;
	logic signed [SAMPLE_BITS-1:0] max_now;

	modport source (output valid, output calibrated, output center_now,
		output min_now, output max_now, input ready);
	modport sink   (input valid, input calibrated, input center_now,
		input min_now, input max_now, output ready);
endinterface

`default_nettype wire

### rtl/amc_div.sv
// ----------------------------------------------------------------------------
// amc_div
// Restoring divider, one compare/subtract per cycle, FRAC_BITS+1 quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module amc_div #(
	parameter int unsigned SAMPLE_BITS = amc_pkg::SampleBitsDef,
	parameter int unsigned FRAC_BITS   = amc_pkg::FracBitsDef
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-1:0] num,
	input  wire logic [SAMPLE_BITS-1:0] den,
	output logic                        done,
	output logic [FRAC_BITS:0]          quo
);
	localparam int unsigned RemW = SAMPLE_BITS + 1;
	localparam int unsigned QuoW = FRAC_BITS + 1;
	localparam int unsigned CntW = $clog2(FRAC_BITS + 2);

	logic [RemW-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [QuoW-1:0] quo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [RemW-1:0] den_x;
	logic            ge;
	logic [RemW-1:0] diff;
	logic [RemW-1:0] next_rem;

	assign den_x    = {1'b0, den_q};
	assign ge       = rem_q >= den_x;
	assign diff     = rem_q - den_x;
	assign next_rem = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(QuoW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// once the remainder is below den, the shifted value fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {next_rem[RemW-2:0], 1'b0};
			quo_q <= {quo_q[QuoW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### rtl/axis_minmax_calibrator.sv
// ----------------------------------------------------------------------------
// axis_minmax_calibrator
// Scale action: the word steps through PREP, MAG, DIV and FIN; in DIV the
// restoring divider retires one quotient bit per cycle. Capture: PREP, FIN.
// Center: PREP, CTR, FIN; zero-span scale: PREP, MAG, FIN. One word in flight
// at a time: next word accepted the cycle after the result loads.
// Async reset: min/max to full range, center 0, min_span 10000, channels idle.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_minmax_calibrator #(
	parameter int unsigned SAMPLE_BITS = amc_pkg::SampleBitsDef,
	parameter int unsigned FRAC_BITS   = amc_pkg::FracBitsDef
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	amc_in_if.sink                                req,
	amc_out_if.source                             rsp,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [amc_pkg::ApbAddrBits-1:0]  paddr,
	input  wire logic [amc_pkg::ApbDataBits-1:0]  pwdata,
	output logic      [amc_pkg::ApbDataBits-1:0]  prdata,
	output logic                                  pready
);
	import amc_pkg::*;

	localparam int unsigned SB   = SAMPLE_BITS;
	localparam int unsigned CmpW = (SB + 1 > MinSpanBits + 1) ? SB + 1 : MinSpanBits + 1;
	localparam int unsigned QuoW = FRAC_BITS + 1;
	localparam logic signed [SB-1:0] SMax = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMin = {1'b1, {(SB-1){1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_MAG  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_CTR  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic signed [SB-1:0] cal_min_q, cal_max_q, cal_center_q;
	logic [MinSpanBits-1:0] min_span_q;

	action_t              act_q;
	logic signed [SB-1:0] smp_q;
	logic signed [SB:0]   num_q, den_q;
	logic                 zero_q, neg_q;
	logic signed [FRAC_BITS+1:0] calib_q;

	logic                        rsp_valid_q;
	logic signed [FRAC_BITS+1:0] rsp_calib_q;
	logic signed [SB-1:0]        rsp_center_q, rsp_min_q, rsp_max_q;

	// config port
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ApbAddrBits-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_span_q <= MinSpanReset;
		end else if (cfg_wr && cfg_idx == REG_MIN_SPAN) begin
			min_span_q <= pwdata[MinSpanBits-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (cfg_idx == REG_MIN_SPAN) begin
			prdata = ApbDataBits'(min_span_q);
		end
	end

	// datapath terms
	logic signed [SB:0] smp_x, min_x, max_x, ctr_x;
	logic signed [SB:0] up_span, dn_span, num_d, span, sum, sum_adj, half;
	logic               above, below;
	logic signed [CmpW-1:0] span_c, min_span_c;
	logic [SB:0]        num_abs, den_abs;

	assign smp_x   = (SB+1)'(smp_q);
	assign min_x   = (SB+1)'(cal_min_q);
	assign max_x   = (SB+1)'(cal_max_q);
	assign ctr_x   = (SB+1)'(cal_center_q);
	assign above   = smp_q > cal_center_q;
	assign below   = smp_q < cal_center_q;
	assign num_d   = smp_x - ctr_x;
	assign up_span = max_x - ctr_x;
	assign dn_span = ctr_x - min_x;
	assign span    = max_x - min_x;
	assign span_c     = CmpW'(span);
	assign min_span_c = $signed(CmpW'(min_span_q));
	// midpoint truncated toward zero
	assign sum     = min_x + max_x;
	assign sum_adj = sum + $signed({{SB{1'b0}}, sum[SB]});
	assign half    = sum_adj >>> 1;
	assign num_abs = num_q[SB] ? -num_q : num_q;
	assign den_abs = den_q[SB] ? -den_q : den_q;

	// divider for the scale action
	logic              div_start, div_done;
	logic [QuoW-1:0]   div_quo;
	logic [QuoW-1:0]   res_mag;
	logic [FRAC_BITS+1:0] res_ext;

	amc_div #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_abs[SB-1:0]),
		.den    (den_abs[SB-1:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// integer quotient bit set means the ratio reached one: clamp
	assign res_mag   = div_quo[QuoW-1] ? (QuoW'(1) << FRAC_BITS) : div_quo;
	assign res_ext   = {1'b0, res_mag};
	assign div_start = (state_q == ST_MAG) && !zero_q;

	logic rsp_load;
	assign rsp_load = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req.valid) state_d = ST_PREP;
			ST_PREP: begin
				unique case (act_q)
					ACT_SCALE:  state_d = ST_MAG;
					ACT_CENTER: state_d = ST_CTR;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_MAG:  state_d = zero_q ? ST_FIN : ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_FIN;
			ST_CTR:  state_d = ST_FIN;
			ST_FIN:  if (rsp_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cal_min_q    <= SMin;
			cal_max_q    <= SMax;
			cal_center_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) begin
				unique case (act_q)
					ACT_BEGIN: begin
						cal_min_q <= SMax;
						cal_max_q <= SMin;
					end
					ACT_WIDEN: begin
						if (smp_q < cal_min_q) cal_min_q <= smp_q;
						if (smp_q > cal_max_q) cal_max_q <= smp_q;
					end
					ACT_CENTER: begin
						if (span_c < min_span_c) begin
							cal_min_q <= SMin;
							cal_max_q <= SMax;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_CTR) begin
				cal_center_q <= half[SB-1:0];
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// word payload and divider operands
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			act_q <= req.action;
			smp_q <= req.sample;
		end
		if (state_q == ST_PREP) begin
			calib_q <= '0;
			num_q   <= num_d;
			den_q   <= above ? up_span : dn_span;
			zero_q  <= !((above && cal_max_q != cal_center_q) ||
				(below && cal_min_q != cal_center_q));
		end
		if (state_q == ST_MAG) begin
			neg_q <= num_q[SB] ^ den_q[SB];
		end
		if (state_q == ST_DIV && div_done) begin
			calib_q <= neg_q ? -$signed(res_ext) : $signed(res_ext);
		end
		if (rsp_load) begin
			rsp_calib_q  <= calib_q;
			rsp_center_q <= cal_center_q;
			rsp_min_q    <= cal_min_q;
			rsp_max_q    <= cal_max_q;
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.calibrated = rsp_calib_q;
	assign rsp.center_now = rsp_center_q;
	assign rsp.min_now    = rsp_min_q;
	assign rsp.max_now    = rsp_max_q;

endmodule

`default_nettype wire
